// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked on the next clock.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/lrts_pkg.sv =====
// Package: payload types, constants and tables of the ring yaw time stamper.
package lrts_pkg;
  localparam int NumRingsDef = 32;
  localparam int CordicSteps = 15;
  localparam int QueueDepth  = 2;

  localparam logic [1:0] RegBlind = 2'd0;
  localparam logic [1:0] RegDecim = 2'd1;
  localparam logic [1:0] RegTsGiven = 2'd2;
  localparam logic [1:0] RegTurn = 2'd3;

  typedef struct packed {
    logic               cloud_start;
    logic signed [23:0] x_mm;
    logic signed [23:0] y_mm;
    logic signed [23:0] z_mm;
    logic [7:0]         intensity;
    logic [7:0]         ring;
    logic [52:0]        timestamp_us;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] out_x_mm;
    logic signed [23:0] out_y_mm;
    logic signed [23:0] out_z_mm;
    logic [7:0]         out_intensity;
    logic signed [31:0] time_offset_us;
  } out_word_t;

  // Front to back: classified point.
  typedef struct packed {
    logic               cloud_start;
    logic               keep;      // index and radius tests passed
    logic               ts_mode;
    logic [7:0]         ring;
    logic [15:0]        yaw;
    logic signed [31:0] ts_off;
    logic signed [23:0] x_mm;
    logic signed [23:0] y_mm;
    logic signed [23:0] z_mm;
    logic [7:0]         intensity;
  } job_t;

  function automatic logic [15:0] atan_bam(input logic [3:0] i);
    case (i)
      4'd0: atan_bam = 16'd8192;  4'd1: atan_bam = 16'd4836;
      4'd2: atan_bam = 16'd2555;  4'd3: atan_bam = 16'd1297;
      4'd4: atan_bam = 16'd651;   4'd5: atan_bam = 16'd326;
      4'd6: atan_bam = 16'd163;   4'd7: atan_bam = 16'd81;
      4'd8: atan_bam = 16'd41;    4'd9: atan_bam = 16'd20;
      4'd10: atan_bam = 16'd10;   4'd11: atan_bam = 16'd5;
      4'd12: atan_bam = 16'd3;    4'd13: atan_bam = 16'd1;
      4'd14: atan_bam = 16'd1;
      default: atan_bam = 16'd0;
    endcase
  endfunction
endpackage

// ===== design/lrts_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
module lrts_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/lrts_front.sv =====
// Front: iterative CORDIC yaw, radius test, decimation and timestamp offset.
module lrts_front import lrts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  input  logic [15:0] blind_radius_mm,
  input  logic [7:0]  decimation_step,
  input  logic        timestamps_given,
  output logic        job_valid,
  input  logic        job_stall,
  output job_t        job
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SQ = 4'b0010, S_ITER = 4'b0100, S_DONE = 4'b1000
  } fstate_t;

  fstate_t state;
  in_word_t pt;
  logic [52:0] head_ts;
  logic [7:0] phase;
  logic keep_idx;
  logic [3:0] it;
  logic signed [35:0] cx, cy;
  logic [15:0] ang;
  logic [1:0] sq_sel;
  logic [47:0] r2;
  logic [47:0] sq;
  logic signed [23:0] sq_in;
  logic signed [31:0] ts_off;
  logic signed [53:0] diff;
  logic [7:0] step;
  logic [8:0] phase_inc;
  logic signed [35:0] dx, dy;

  assign in_stall = (state != S_IDLE);
  assign step = (decimation_step == 8'd0) ? 8'd1 : decimation_step;
  assign phase_inc = {1'b0, (in_data.cloud_start ? 8'd0 : phase)} + 9'd1;
  assign diff = $signed({1'b0, pt.timestamp_us}) - $signed({1'b0, head_ts});
  assign sq_in = (sq_sel == 2'd0) ? pt.x_mm : ((sq_sel == 2'd1) ? pt.y_mm : pt.z_mm);
  assign sq = 48'($signed(sq_in) * $signed(sq_in));
  assign dx = cy >>> it;
  assign dy = cx >>> it;

  always_comb begin
    if (diff > 54'sd2147483647) ts_off = 32'sh7fffffff;
    else if (diff < -54'sd2147483648) ts_off = 32'sh80000000;
    else ts_off = diff[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head_ts <= '0;
      phase <= '0;
      job_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!job_valid || !job_stall)) job_valid <= 1'b1;
      else if (!job_stall) job_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pt <= in_data;
            if (in_data.cloud_start) head_ts <= in_data.timestamp_us;
            keep_idx <= in_data.cloud_start || (phase == 8'd0);
            phase <= (phase_inc >= {1'b0, step}) ? 8'd0 : phase_inc[7:0];
            r2 <= '0;
            sq_sel <= 2'd0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          r2 <= r2 + sq;
          if (sq_sel == 2'd2) begin
            it <= '0;
            if (pt.x_mm < 0) begin
              cx <= -(36'(pt.x_mm) <<< 8);
              cy <= -(36'(pt.y_mm) <<< 8);
              ang <= 16'd32768;
            end else begin
              cx <= 36'(pt.x_mm) <<< 8;
              cy <= 36'(pt.y_mm) <<< 8;
              ang <= 16'd0;
            end
            state <= S_ITER;
          end
          sq_sel <= sq_sel + 2'd1;
        end
        S_ITER: begin
          if (cy >= 0) begin
            cx <= cx + dx; cy <= cy - dy; ang <= ang + atan_bam(it);
          end else begin
            cx <= cx - dx; cy <= cy + dy; ang <= ang - atan_bam(it);
          end
          it <= it + 4'd1;
          if (it == 4'(CordicSteps - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (!job_valid || !job_stall) begin
            job.cloud_start <= pt.cloud_start;
            job.keep <= keep_idx &&
                        (r2 > 48'(blind_radius_mm * blind_radius_mm));
            job.ts_mode <= timestamps_given;
            job.ring <= pt.ring;
            job.yaw <= (pt.x_mm == 0 && pt.y_mm == 0) ? 16'd0 : ang;
            job.ts_off <= ts_off;
            job.x_mm <= pt.x_mm;
            job.y_mm <= pt.y_mm;
            job.z_mm <= pt.z_mm;
            job.intensity <= pt.intensity;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `CHK_IMPLY(a_stall_busy, state != S_IDLE, in_stall, "front busy without stall")
  `CHK_NEXT(a_iter_done, state == S_ITER && it == 4'(CordicSteps - 1), state == S_DONE, "cordic overrun")
  `CHK_IMPLY(a_phase_range, state == S_SQ, phase < step || decimation_step == 8'd0, "phase range")
endmodule

// ===== design/lrts_queue.sv =====
// Short FIFO of classified points between front and back.
module lrts_queue import lrts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_stall,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output job_t rd_data
);
  localparam int AW = $clog2(QueueDepth);
  job_t q [QueueDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic push, pop;

  assign wr_stall = (cnt == (AW+1)'(QueueDepth));
  assign rd_valid = (cnt != '0);
  assign rd_data = q[rp];
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) q[wp] <= wr_data;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(QueueDepth - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(QueueDepth - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  `include "assert_macros.svh"
  `CHK_IMPLY(a_no_overflow, push, cnt < (AW+1)'(QueueDepth), "queue overflow")
  `CHK_IMPLY(a_no_underflow, pop, cnt != '0, "queue underflow")
  `CHK_NEXT(a_count, push && !pop, cnt == $past(cnt) + 1'b1, "count slip")
endmodule

// ===== design/lrts_back.sv =====
// Back: per-ring yaw time state, multiply, output register.
module lrts_back import lrts_pkg::*; #(
  parameter int NumRings = NumRingsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_stall,
  input  job_t        job,
  input  logic [19:0] turn_period_us,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data
);
  localparam int RW = (NumRings > 1) ? $clog2(NumRings) : 1;
  typedef enum logic [3:0] {
    B_IDLE = 4'b0001, B_READ = 4'b0010, B_MUL = 4'b0100, B_EMIT = 4'b1000
  } bstate_t;

  bstate_t state;
  job_t j;
  logic [NumRings-1:0] seen;
  logic [RW-1:0] ra;
  logic [RW-1:0] rd_addr;
  logic [15:0] fy_rd;
  logic [31:0] lt_rd;
  logic fy_we, lt_we;
  logic [15:0] fy_wd;
  logic [31:0] lt_wd;
  logic [35:0] prod;
  logic [31:0] tval;
  logic [31:0] t_adj;
  logic signed [31:0] toff;
  logic in_range;
  logic emit_fire;

  assign ra = j.ring[RW-1:0];
  // read ahead with the incoming ring so the first yaw is ready in B_READ
  assign rd_addr = (state == B_IDLE) ? job.ring[RW-1:0] : ra;
  assign in_range = ({24'd0, j.ring} < 32'(NumRings));
  assign tval = 32'(prod >> 16);
  assign t_adj = (tval < lt_rd) ? tval + 32'(turn_period_us) : tval;
  assign job_stall = (state != B_IDLE);
  assign emit_fire = (state == B_EMIT) && (!out_valid || !out_stall);
  assign fy_wd = j.yaw;

  lrts_ram #(.Width(16), .Depth(NumRings)) u_fy (
    .clk, .we(fy_we), .waddr(ra), .wdata(fy_wd), .raddr(rd_addr), .rdata(fy_rd));
  lrts_ram #(.Width(32), .Depth(NumRings)) u_lt (
    .clk, .we(lt_we), .waddr(ra), .wdata(lt_wd), .raddr(rd_addr), .rdata(lt_rd));

  // first point of a ring: store its yaw, time restarts at zero
  always_comb begin
    fy_we = 1'b0;
    lt_we = 1'b0;
    lt_wd = '0;
    if (state == B_READ && !j.ts_mode && in_range && !seen[ra]) begin
      fy_we = 1'b1; lt_we = 1'b1;
    end else if (state == B_MUL) begin
      lt_we = 1'b1; lt_wd = t_adj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      seen <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_fire) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            j <= job;
            if (job.cloud_start) seen <= '0;
            state <= B_READ;
          end
        end
        B_READ: begin
          if (j.ts_mode) begin
            toff <= j.ts_off;
            state <= j.keep ? B_EMIT : B_IDLE;
          end else if (!in_range) begin
            state <= B_IDLE;
          end else if (!seen[ra]) begin
            seen[ra] <= 1'b1;
            state <= B_IDLE;
          end else begin
            prod <= 36'(16'(fy_rd - j.yaw) * turn_period_us) + 36'd32768;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          // one more turn if time would run backwards on this ring
          toff <= $signed(t_adj);
          state <= j.keep ? B_EMIT : B_IDLE;
        end
        B_EMIT: begin
          if (emit_fire) begin
            out_data.out_x_mm <= j.x_mm;
            out_data.out_y_mm <= j.y_mm;
            out_data.out_z_mm <= j.z_mm;
            out_data.out_intensity <= j.intensity;
            out_data.time_offset_us <= toff;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `CHK_IMPLY(a_emit_keep, state == B_EMIT, j.keep, "emit of dropped point")
  `CHK_NEXT(a_emit_valid, emit_fire, out_valid, "result lost")
  `CHK_IMPLY(a_busy, state != B_IDLE, job_stall, "back busy without stall")
  `CHK_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data), "word changed under stall")
endmodule

// ===== design/lidar_ring_yaw_time_stamper_top.sv =====
// Top level of the LiDAR ring yaw time stamper.
// Usage:
//  - Input channel in_valid/in_stall/in_data carries one point word
//    (in_word_t). Output channel out_valid/out_stall/out_data carries
//    one stamped point word (out_word_t); dropped points give no word.
//  - The front works one point at a time: accept, squaring of x, y and z
//    for the blind-radius test, 15 CORDIC iterations for the yaw, then a
//    handoff; in_stall holds off the next point until the front is idle.
//  - A two-entry queue decouples front from back; in yaw mode the back
//    reads the per-ring RAMs and does one 16x20 multiply, and it
//    registers the result, taking one job at a time.
//  - Reset (rst, synchronous) loads register defaults, clears ring marks,
//    head timestamp and point phase. The per-ring yaw/time RAMs need no
//    clearing; they are written on each ring's first point.
//  - A stalled receiver holds the output word; the back and then the
//    queue fill, and in_stall rises back to the source.
//  - APB registers (word index paddr[3:2]): 0 blind radius, 1 decimation,
//    2 timestamps given, 3 turn period. Write only while idle.
module lidar_ring_yaw_time_stamper_top import lrts_pkg::*; #(
  parameter int NumRings = NumRingsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] blind_radius_mm;
  logic [7:0]  decimation_step;
  logic        timestamps_given;
  logic [19:0] turn_period_us;
  logic fj_valid, fj_stall, bj_valid, bj_stall;
  job_t fj, bj;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blind_radius_mm <= 16'd10;
      decimation_step <= 8'd1;
      timestamps_given <= 1'b1;
      turn_period_us <= 20'd99723;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegBlind: blind_radius_mm <= pwdata[15:0];
        RegDecim: decimation_step <= pwdata[7:0];
        RegTsGiven: timestamps_given <= pwdata[0];
        RegTurn: turn_period_us <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegBlind: prdata = {16'd0, blind_radius_mm};
      RegDecim: prdata = {24'd0, decimation_step};
      RegTsGiven: prdata = {31'd0, timestamps_given};
      RegTurn: prdata = {12'd0, turn_period_us};
      default: prdata = '0;
    endcase
  end

  lrts_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .blind_radius_mm, .decimation_step, .timestamps_given,
    .job_valid(fj_valid), .job_stall(fj_stall), .job(fj));

  lrts_queue u_queue (
    .clk, .rst, .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_data(fj),
    .rd_valid(bj_valid), .rd_stall(bj_stall), .rd_data(bj));

  lrts_back #(.NumRings(NumRings)) u_back (
    .clk, .rst, .job_valid(bj_valid), .job_stall(bj_stall), .job(bj),
    .turn_period_us, .out_valid, .out_stall, .out_data);
endmodule
